[hw/rtl/saturating_fixed_point_alu_top_defines.svh]
// assertion macros for the saturating fixed-point alu
// no dependencies; included by the top level only
`ifndef SATURATING_FIXED_POINT_ALU_TOP_DEFINES_SVH
`define SATURATING_FIXED_POINT_ALU_TOP_DEFINES_SVH

// checked property, ignored while reset is high
`define SFX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property that also holds across reset
`define SFX_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/sfx_pkg.sv]
// shared types and constants for the saturating fixed-point alu
// no dependencies
`default_nettype none

package sfx_pkg;

   // command codes
   localparam logic [2:0] CMD_FDIV  = 3'd0;
   localparam logic [2:0] CMD_WDIV  = 3'd1;
   localparam logic [2:0] CMD_SQRT  = 3'd2;
   localparam logic [2:0] CMD_ROUND = 3'd3;
   localparam logic [2:0] CMD_MIN   = 3'd4;
   localparam logic [2:0] CMD_MAX   = 3'd5;

   localparam int FRACTION_BITS_DEF = 16;

   localparam int DATA_W    = 32;  // mantissa and result width
   localparam int QUO_BITS  = 33;  // quotient bits produced by the divider
   localparam int STEPS     = 2;   // divider and root bits per stage
   localparam int NUM_STG   = (QUO_BITS + STEPS - 1) / STEPS;

   localparam logic [DATA_W-1:0] INT_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      KIND_DIRECT,
      KIND_DIV,
      KIND_ROOT
   } kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic              neg;
      logic [DATA_W-1:0] direct;
   } ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/saturating_fixed_point_alu_top.sv]
// pipeline: decode, 17 divider/root stages, output
// throughput: one beat per cycle unless rsp stalls; each stage retires up to two quotient and two root bits
// a stalled rsp side freezes the whole pipeline in place, nothing dropped or repeated
// reset (synchronous, active high) clears only the stage valid bits
// depends on sfx_pkg, sfx_decode, sfx_step, sfx_finish and the defines header
`default_nettype none

`include "saturating_fixed_point_alu_top_defines.svh"

module saturating_fixed_point_alu_top #(
   parameter int FRACTION_BITS = sfx_pkg::FRACTION_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [103:0] req_tdata,  // cmd[2:0], operand_a[34:3], operand_b[98:35], zero pad
   // response stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata   // result[31:0]
);
   localparam int QB  = sfx_pkg::QUO_BITS;
   localparam int RB  = (32 + FRACTION_BITS) / 2;
   localparam int RW  = RB + 3;
   localparam int XW  = 2 * RB;
   localparam int NS  = sfx_pkg::NUM_STG;

   // pipeline moves as one when the output slot is free or being drained
   logic advance;

   // stage 0 is the decode register, stage NS feeds the output register
   sfx_pkg::ctrl_type stg_ctrl  [NS+1];
   logic [QB-1:0]     stg_drem  [NS+1];
   logic [QB-1:0]     stg_dlow  [NS+1];
   logic [31:0]       stg_dden  [NS+1];
   logic [QB-1:0]     stg_dquo  [NS+1];
   logic [RW-1:0]     stg_rrem  [NS+1];
   logic [XW-1:0]     stg_rlow  [NS+1];
   logic [RB-1:0]     stg_rroot [NS+1];

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   sfx_decode #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_tvalid),
      .cmd       (req_tdata[2:0]),
      .operand_a (req_tdata[34:3]),
      .operand_b (req_tdata[98:35]),
      .ctrl_out  (stg_ctrl[0]),
      .drem_out  (stg_drem[0]),
      .dlow_out  (stg_dlow[0]),
      .dden_out  (stg_dden[0]),
      .rlow_out  (stg_rlow[0])
   );

   // quotient and root start empty
   assign stg_dquo[0]  = '0;
   assign stg_rrem[0]  = '0;
   assign stg_rroot[0] = '0;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      sfx_step #(
         .FRACTION_BITS (FRACTION_BITS),
         .FIRST         (s * sfx_pkg::STEPS)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .enable  (advance),
         .ctrl_i  (stg_ctrl[s]),
         .drem_i  (stg_drem[s]),
         .dlow_i  (stg_dlow[s]),
         .dden_i  (stg_dden[s]),
         .dquo_i  (stg_dquo[s]),
         .rrem_i  (stg_rrem[s]),
         .rlow_i  (stg_rlow[s]),
         .rroot_i (stg_rroot[s]),
         .ctrl_o  (stg_ctrl[s+1]),
         .drem_o  (stg_drem[s+1]),
         .dlow_o  (stg_dlow[s+1]),
         .dden_o  (stg_dden[s+1]),
         .dquo_o  (stg_dquo[s+1]),
         .rrem_o  (stg_rrem[s+1]),
         .rlow_o  (stg_rlow[s+1]),
         .rroot_o (stg_rroot[s+1])
      );
   end

   sfx_finish #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .ctrl_i    (stg_ctrl[NS]),
      .dquo_i    (stg_dquo[NS]),
      .rroot_i   (stg_rroot[NS]),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   // no beat may appear right after reset
   `SFX_ASSERT_RST(a_rsp_idle_after_reset, $past(reset) |-> !rsp_tvalid, "rsp beat right after reset")

   // zero divisors must have been resolved before the divider
   `SFX_ASSERT(a_div_nonzero_den, stg_ctrl[0].valid && stg_ctrl[0].kind == sfx_pkg::KIND_DIV |-> stg_dden[0] != 32'd0, "divider got a zero divisor")

   // root only entered for a strictly positive operand
   `SFX_ASSERT(a_root_positive, stg_ctrl[0].valid && stg_ctrl[0].kind == sfx_pkg::KIND_ROOT |-> stg_rlow[0] != '0, "root entered with zero operand")

   // a stalled pipeline keeps its first stage intact
   `SFX_ASSERT(a_stall_holds, !$past(advance) && !$past(reset) |-> $stable(stg_ctrl[0]), "decode stage changed during stall")

endmodule

`default_nettype wire

[hw/rtl/sfx_decode.sv]
// operand decode stage: clamps, magnitudes, special results, divider/root setup
// depends on sfx_pkg
`default_nettype none

module sfx_decode #(
   parameter int FRACTION_BITS = sfx_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic                             in_valid,
   input  wire logic [2:0]                       cmd,
   input  wire logic [31:0]                      operand_a,
   input  wire logic [63:0]                      operand_b,
   output sfx_pkg::ctrl_type                     ctrl_out,
   output logic [sfx_pkg::QUO_BITS-1:0]          drem_out,
   output logic [sfx_pkg::QUO_BITS-1:0]          dlow_out,
   output logic [sfx_pkg::DATA_W-1:0]            dden_out,
   output logic [2*((32+FRACTION_BITS)/2)-1:0]   rlow_out
);
   localparam int NW = 32 + FRACTION_BITS;
   localparam int RB = (32 + FRACTION_BITS) / 2;
   localparam int XW = 2 * RB;
   localparam int HW = NW - sfx_pkg::QUO_BITS;
   localparam logic [32:0] HALF = 33'(1) << (FRACTION_BITS - 1);

   logic [31:0]   bq;
   logic [31:0]   mag_a;
   logic [31:0]   mag_bq;
   logic [63:0]   mag_b;
   logic [31:0]   zdiv;
   logic [NW-1:0] num;
   logic [HW-1:0] num_hi;
   logic [32:0]   rsum;
   logic [31:0]   rmag;
   sfx_pkg::ctrl_type ctrl_in;
   logic [31:0]   den_in;
   logic [XW-1:0] x_in;

   sfx_pkg::ctrl_type               ctrl_ff;
   logic [sfx_pkg::QUO_BITS-1:0]    drem_ff;
   logic [sfx_pkg::QUO_BITS-1:0]    dlow_ff;
   logic [31:0]                     dden_ff;
   logic [XW-1:0]                   rlow_ff;

   always_comb begin
      // operand_b seen as a 32-bit mantissa
      bq = operand_b[31:0];
      if (!operand_b[63] && (|operand_b[62:31])) begin
         bq = sfx_pkg::INT_MAX;
      end else if (operand_b[63] && !(&operand_b[62:31])) begin
         bq = sfx_pkg::INT_MIN;
      end
      mag_a  = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
      mag_bq = bq[31] ? (~bq + 32'd1) : bq;
      mag_b  = operand_b[63] ? (~operand_b + 64'd1) : operand_b;
      if (operand_a[31]) begin
         zdiv = sfx_pkg::INT_MIN;
      end else if (operand_a == 32'd0) begin
         zdiv = 32'd0;
      end else begin
         zdiv = sfx_pkg::INT_MAX;
      end
      rsum = {1'b0, mag_a} + HALF;
      rmag = 32'(rsum >> FRACTION_BITS);

      ctrl_in.valid  = in_valid;
      ctrl_in.kind   = sfx_pkg::KIND_DIRECT;
      ctrl_in.neg    = operand_a[31];
      ctrl_in.direct = 32'd0;
      num            = NW'(mag_a);
      den_in         = mag_bq;
      x_in           = XW'({operand_a[30:0], {FRACTION_BITS{1'b0}}});

      case (cmd)
         sfx_pkg::CMD_FDIV: begin
            num         = {mag_a, {FRACTION_BITS{1'b0}}};
            ctrl_in.neg = operand_a[31] ^ operand_b[63];
            if (bq == 32'd0) begin
               ctrl_in.direct = zdiv;
            end else begin
               ctrl_in.kind = sfx_pkg::KIND_DIV;
            end
         end
         sfx_pkg::CMD_WDIV: begin
            den_in      = mag_b[31:0];
            ctrl_in.neg = operand_a[31] ^ operand_b[63];
            if (operand_b == 64'd0) begin
               ctrl_in.direct = zdiv;
            end else if (mag_b[63:32] == 32'd0) begin
               ctrl_in.kind = sfx_pkg::KIND_DIV;
            end
         end
         sfx_pkg::CMD_SQRT: begin
            if (!operand_a[31] && (operand_a != 32'd0)) begin
               ctrl_in.kind = sfx_pkg::KIND_ROOT;
            end
         end
         sfx_pkg::CMD_ROUND: begin
            ctrl_in.direct = operand_a[31] ? (~rmag + 32'd1) : rmag;
         end
         sfx_pkg::CMD_MIN: begin
            ctrl_in.direct = ($signed(bq) < $signed(operand_a)) ? bq : operand_a;
         end
         sfx_pkg::CMD_MAX: begin
            ctrl_in.direct = ($signed(bq) > $signed(operand_a)) ? bq : operand_a;
         end
         default: begin
            ctrl_in.direct = 32'd0;
         end
      endcase

      // quotient too large for the divider: saturate right here
      num_hi = num[NW-1:sfx_pkg::QUO_BITS];
      if (ctrl_in.kind == sfx_pkg::KIND_DIV && 32'(num_hi) >= den_in) begin
         ctrl_in.kind   = sfx_pkg::KIND_DIRECT;
         ctrl_in.direct = ctrl_in.neg ? sfx_pkg::INT_MIN : sfx_pkg::INT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (enable) begin
         ctrl_ff.kind   <= ctrl_in.kind;
         ctrl_ff.neg    <= ctrl_in.neg;
         ctrl_ff.direct <= ctrl_in.direct;
         drem_ff        <= sfx_pkg::QUO_BITS'(num_hi);
         dlow_ff        <= num[sfx_pkg::QUO_BITS-1:0];
         dden_ff        <= den_in;
         rlow_ff        <= x_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign drem_out = drem_ff;
   assign dlow_out = dlow_ff;
   assign dden_out = dden_ff;
   assign rlow_out = rlow_ff;

endmodule

`default_nettype wire

[hw/rtl/sfx_step.sv]
// one pipeline stage of the restoring divider and the bit-pair square root
// depends on sfx_pkg
`default_nettype none

module sfx_step #(
   parameter int FRACTION_BITS = sfx_pkg::FRACTION_BITS_DEF,
   parameter int FIRST         = 0
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                enable,
   input  wire sfx_pkg::ctrl_type                   ctrl_i,
   input  wire logic [sfx_pkg::QUO_BITS-1:0]        drem_i,
   input  wire logic [sfx_pkg::QUO_BITS-1:0]        dlow_i,
   input  wire logic [sfx_pkg::DATA_W-1:0]          dden_i,
   input  wire logic [sfx_pkg::QUO_BITS-1:0]        dquo_i,
   input  wire logic [(32+FRACTION_BITS)/2+2:0]     rrem_i,
   input  wire logic [2*((32+FRACTION_BITS)/2)-1:0] rlow_i,
   input  wire logic [(32+FRACTION_BITS)/2-1:0]     rroot_i,
   output sfx_pkg::ctrl_type                        ctrl_o,
   output logic [sfx_pkg::QUO_BITS-1:0]             drem_o,
   output logic [sfx_pkg::QUO_BITS-1:0]             dlow_o,
   output logic [sfx_pkg::DATA_W-1:0]               dden_o,
   output logic [sfx_pkg::QUO_BITS-1:0]             dquo_o,
   output logic [(32+FRACTION_BITS)/2+2:0]          rrem_o,
   output logic [2*((32+FRACTION_BITS)/2)-1:0]      rlow_o,
   output logic [(32+FRACTION_BITS)/2-1:0]          rroot_o
);
   localparam int QB = sfx_pkg::QUO_BITS;
   localparam int RB = (32 + FRACTION_BITS) / 2;
   localparam int RW = RB + 3;
   localparam int XW = 2 * RB;

   logic [QB-1:0] drem_in, dlow_in, dquo_in, drem2;
   logic [RW-1:0] rrem_in, rrem2, trial;
   logic [XW-1:0] rlow_in;
   logic [RB-1:0] rroot_in;

   sfx_pkg::ctrl_type ctrl_ff;
   logic [QB-1:0]     drem_ff, dlow_ff, dquo_ff;
   logic [31:0]       dden_ff;
   logic [RW-1:0]     rrem_ff;
   logic [XW-1:0]     rlow_ff;
   logic [RB-1:0]     rroot_ff;

   always_comb begin
      drem_in  = drem_i;
      dlow_in  = dlow_i;
      dquo_in  = dquo_i;
      rrem_in  = rrem_i;
      rlow_in  = rlow_i;
      rroot_in = rroot_i;
      drem2    = '0;
      rrem2    = '0;
      trial    = '0;
      for (int k = 0; k < sfx_pkg::STEPS; k++) begin
         if (FIRST + k < QB) begin
            drem2   = {drem_in[QB-2:0], dlow_in[QB-1]};
            dlow_in = dlow_in << 1;
            if (drem2 >= {1'b0, dden_i}) begin
               drem_in = drem2 - {1'b0, dden_i};
               dquo_in = {dquo_in[QB-2:0], 1'b1};
            end else begin
               drem_in = drem2;
               dquo_in = {dquo_in[QB-2:0], 1'b0};
            end
         end
         if (FIRST + k < RB) begin
            rrem2   = {rrem_in[RW-3:0], rlow_in[XW-1:XW-2]};
            rlow_in = rlow_in << 2;
            trial   = RW'({rroot_in, 2'b01});
            if (rrem2 >= trial) begin
               rrem_in  = rrem2 - trial;
               rroot_in = {rroot_in[RB-2:0], 1'b1};
            end else begin
               rrem_in  = rrem2;
               rroot_in = {rroot_in[RB-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctrl_ff.valid <= ctrl_i.valid;
      end
      if (enable) begin
         ctrl_ff.kind   <= ctrl_i.kind;
         ctrl_ff.neg    <= ctrl_i.neg;
         ctrl_ff.direct <= ctrl_i.direct;
         drem_ff        <= drem_in;
         dlow_ff        <= dlow_in;
         dden_ff        <= dden_i;
         dquo_ff        <= dquo_in;
         rrem_ff        <= rrem_in;
         rlow_ff        <= rlow_in;
         rroot_ff       <= rroot_in;
      end
   end

   assign ctrl_o  = ctrl_ff;
   assign drem_o  = drem_ff;
   assign dlow_o  = dlow_ff;
   assign dden_o  = dden_ff;
   assign dquo_o  = dquo_ff;
   assign rrem_o  = rrem_ff;
   assign rlow_o  = rlow_ff;
   assign rroot_o = rroot_ff;

endmodule

`default_nettype wire

[hw/rtl/sfx_finish.sv]
// output stage: sign, clamp and result select into the output register
// depends on sfx_pkg
`default_nettype none

module sfx_finish #(
   parameter int FRACTION_BITS = sfx_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            enable,
   input  wire sfx_pkg::ctrl_type               ctrl_i,
   input  wire logic [sfx_pkg::QUO_BITS-1:0]    dquo_i,
   input  wire logic [(32+FRACTION_BITS)/2-1:0] rroot_i,
   output logic                                 out_valid,
   output logic [sfx_pkg::DATA_W-1:0]           out_data
);
   logic [31:0] res_in;
   logic        valid_ff;
   logic [31:0] res_ff;

   always_comb begin
      case (ctrl_i.kind)
         sfx_pkg::KIND_DIV: begin
            if (!ctrl_i.neg) begin
               res_in = (dquo_i > sfx_pkg::QUO_BITS'(sfx_pkg::INT_MAX)) ?
                        sfx_pkg::INT_MAX : dquo_i[31:0];
            end else begin
               res_in = (dquo_i > sfx_pkg::QUO_BITS'(sfx_pkg::INT_MIN)) ?
                        sfx_pkg::INT_MIN : (~dquo_i[31:0] + 32'd1);
            end
         end
         sfx_pkg::KIND_ROOT: begin
            res_in = 32'(rroot_i);
         end
         default: begin
            res_in = ctrl_i.direct;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= ctrl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = res_ff;

endmodule

`default_nettype wire
